// ===== sv/pidl_pkg.sv =====
// Shared types and constants for the positional insert/delete list.
package pidl_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Register select taken from paddr above the byte offset.
  localparam logic [APB_AW-3:0] REG_CAP = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_BAD_COUNT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_READ,
    S_COMMIT,
    S_DONE
  } seq_e;

  typedef struct packed {
    logic             wr_en;
    logic [VAL_W-1:0] wr_data;
  } ram_wr_t;

endpackage

// ===== sv/pidl_if.sv =====
// Request and response channel interfaces of the positional list.
interface pidl_req_if;
  import pidl_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;
  logic [POS_W-1:0] count;

  modport source(output valid, req_type, position, value, count, input ready);
  modport sink(input valid, req_type, position, value, count, output ready);
endinterface

interface pidl_rsp_if;
  import pidl_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  read_value;
  logic [LEN_W-1:0]  length;

  modport source(output valid, status, read_value, length, input ready);
  modport sink(input valid, status, read_value, length, output ready);
endinterface

// ===== sv/pidl_store.sv =====
// Single write port, single registered read port entry memory.
module pidl_store #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  pidl_pkg::ram_wr_t           wr_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [pidl_pkg::VAL_W-1:0]  rd_data_o
);
  import pidl_pkg::*;

  logic [VAL_W-1:0] mem_q [Depth];
  logic [VAL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_i.wr_data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/positional_insert_delete_list_top.sv =====
// Top level of the positional insert/delete list with its sequencer and config port.
// Flow: clear, remove-last-k, the unused codes and failed requests go from acceptance
// straight to the done state, a read through the read state; insert and delete pass through
// the shift and commit states, the memory moving one entry per cycle during the shift.
// Throughput: one request at a time; ready returns once the result is in the output register.
// Reset clears the length and sets the capacity limit to 64; the memory is not swept.
module positional_insert_delete_list_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pidl_req_if.sink                     req_i,
  pidl_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidl_pkg::APB_AW-1:0]  paddr,
  input  logic [pidl_pkg::APB_DW-1:0]  pwdata,
  output logic [pidl_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import pidl_pkg::*;

  // AW indexes a slot, CW holds a length up to DEPTH, and XW is the common
  // compare width of a length and the 7-bit request fields.
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  // Entries live in slots 0 .. length-1. A slot at or above the length is
  // never read: reads check the index and shifts only touch live slots. So
  // delete, remove and clear vacate slots only by moving the length, and the memory needs
  // neither a reset sweep nor zeroing of vacated slots.

  seq_e              state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CAP_W-1:0]  cap_q;
  logic [AW-1:0]     src_q, src_d;
  logic [AW-1:0]     dst_q, dst_d;
  logic [AW-1:0]     at_q, at_d;
  logic [CW-1:0]     mv_q, mv_d;
  logic              pend_q, pend_d;
  logic              up_q, up_d;
  logic              ins_q, ins_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [VAL_W-1:0]  res_rd_q, res_rd_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [VAL_W-1:0]  out_rd_q, out_rd_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;

  logic              req_fire;
  logic              out_free;
  logic              cfg_write;
  logic [XW-1:0]     cnt_x, pos_x, cntreq_x, cap_x;
  logic [XW-1:0]     at_x, ins_mv_x, del_mv_x;
  logic              full;
  status_e           dec_status;
  logic              go_shift;
  logic              go_read;

  ram_wr_t           ram_wr;
  logic [AW-1:0]     ram_wr_addr;
  logic [AW-1:0]     ram_rd_addr;
  logic [VAL_W-1:0]  ram_rd_data;

  pidl_store #(
    .Depth(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_i     (ram_wr),
    .wr_addr_i(ram_wr_addr),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  // Configuration port. Writes complete in the access phase; only the
  // capacity register exists, and other addresses read as zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[APB_AW-1:2] == REG_CAP);
  assign prdata    = (paddr[APB_AW-1:2] == REG_CAP) ? APB_DW'(cap_q) : '0;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.read_value = out_rd_q;
  assign rsp_o.length     = out_len_q;

  // Request decode, all in the compare width.
  assign cnt_x    = XW'(count_q);
  assign pos_x    = XW'(req_i.position);
  assign cntreq_x = XW'(req_i.count);
  assign cap_x    = XW'(cap_q);
  assign full     = (cnt_x >= cap_x) || (cnt_x >= DEPTH_X);
  // Position zero appends; otherwise the new entry goes into slot p-1, before the entry held there.
  assign at_x     = (pos_x == '0) ? cnt_x : pos_x - XW'(1);
  assign ins_mv_x = cnt_x - at_x;
  assign del_mv_x = cnt_x - pos_x - XW'(1);

  always_comb begin
    dec_status = STAT_OK;
    go_shift   = 1'b0;
    go_read    = 1'b0;
    unique case (req_i.req_type)
      REQ_INSERT: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else if (pos_x > cnt_x) begin
          dec_status = STAT_BAD_INDEX;
        end else begin
          go_shift = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (pos_x >= cnt_x) begin
          dec_status = STAT_BAD_INDEX;
        end else begin
          go_shift = 1'b1;
        end
      end
      REQ_REMOVE: begin
        // A count equal to the length, and any count on an empty list, fails.
        if (cntreq_x >= cnt_x) begin
          dec_status = STAT_BAD_COUNT;
        end
      end
      REQ_READ: begin
        if (pos_x >= cnt_x) begin
          dec_status = STAT_BAD_INDEX;
        end else begin
          go_read = 1'b1;
        end
      end
      default: begin
        // Clear and the unused codes always succeed.
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (go_shift) begin
            state_d = S_SHIFT;
          end else if (go_read) begin
            state_d = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if ((mv_q == '0) && !pend_q) begin
          state_d = S_COMMIT;
        end
      end
      S_READ:   state_d = S_DONE;
      S_COMMIT: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control. The shift is pipelined through the
  // registered read: each cycle writes the word read in the cycle before
  // while the next source slot is read.
  always_comb begin
    count_d      = count_q;
    src_d        = src_q;
    dst_d        = dst_q;
    at_d         = at_q;
    mv_d         = mv_q;
    pend_d       = 1'b0;
    up_d         = up_q;
    ins_d        = ins_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_rd_d     = out_rd_q;
    out_len_d    = out_len_q;
    ram_wr       = '{wr_en: 1'b0, wr_data: ram_rd_data};
    ram_wr_addr  = dst_q;
    ram_rd_addr  = src_q;

    unique case (state_q)
      S_IDLE: begin
        ram_rd_addr = pos_x[AW-1:0];
        if (req_fire) begin
          res_status_d = dec_status;
          res_rd_d     = '0;
          val_d        = req_i.value;
          ins_d        = (req_i.req_type == REQ_INSERT);
          if (ins_d) begin
            // Move entries at..length-1 up one slot, walking downward.
            up_d  = 1'b1;
            at_d  = at_x[AW-1:0];
            mv_d  = ins_mv_x[CW-1:0];
            src_d = AW'(cnt_x - XW'(1));
          end else begin
            // Move entries pos+1..length-1 down one slot, walking upward.
            up_d  = 1'b0;
            mv_d  = del_mv_x[CW-1:0];
            src_d = AW'(pos_x + XW'(1));
          end
          if (dec_status == STAT_OK) begin
            if (req_i.req_type == REQ_REMOVE) begin
              count_d = count_q - CW'(cntreq_x);
            end else if (req_i.req_type == REQ_CLEAR) begin
              count_d = '0;
            end
          end
        end
      end
      S_SHIFT: begin
        ram_wr.wr_en = pend_q;
        if (mv_q != '0) begin
          pend_d = 1'b1;
          mv_d   = mv_q - CW'(1);
          if (up_q) begin
            dst_d = src_q + AW'(1);
            src_d = src_q - AW'(1);
          end else begin
            dst_d = src_q - AW'(1);
            src_d = src_q + AW'(1);
          end
        end
      end
      S_READ: begin
        res_rd_d = ram_rd_data;
      end
      S_COMMIT: begin
        if (ins_q) begin
          ram_wr      = '{wr_en: 1'b1, wr_data: val_q};
          ram_wr_addr = at_q;
          count_d     = count_q + CW'(1);
        end else begin
          count_d     = count_q - CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_rd_d     = res_rd_q;
          out_len_d    = cnt_x[LEN_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_write) begin
        cap_q <= pwdata[CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q        <= src_d;
    dst_q        <= dst_d;
    at_q         <= at_d;
    mv_q         <= mv_d;
    up_q         <= up_d;
    ins_q        <= ins_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_rd_q     <= res_rd_d;
    out_status_q <= out_status_d;
    out_rd_q     <= out_rd_d;
    out_len_q    <= out_len_d;
  end

  // The length never passes the number of physical slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= DEPTH_X)
    else $error("list length exceeds DEPTH");

  // A pending shift write exists only while shifting.
  a_pend_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SHIFT))
    else $error("shift write pending outside the shift state");

  // The length holds while entries move, a read waits or a word waits.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT || state_q == S_READ || state_q == S_DONE)
      |=> (count_q == $past(count_q)))
    else $error("length changed outside request start or commit");

  // A committed insert grows the list by exactly one.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && ins_q) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert commit did not grow the list by one");

endmodule

// ===== tb/positional_insert_delete_list_top_tb.sv =====
// Self-checking testbench for the positional insert/delete list: random and directed requests.
module positional_insert_delete_list_top_tb;
  import pidl_pkg::*;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 11;
  // Longest correct stretch without a handshake is one full shift plus the
  // longest random stall on either side, so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned MAX_PRINTED  = 100;

  localparam logic [APB_AW-1:0] CAP_ADDR = {REG_CAP, 2'b00};

  // Request codes 5 to 7 are not decoded; the block must answer them as no-ops.
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
  } list_rsp_t;

  // Shadow copy of the list. Each accepted request is applied here and the
  // word it should produce is queued; each response word is compared with
  // the oldest queued one.
  class list_tracker;
    logic [VAL_W-1:0] slots [LIST_DEPTH];
    int unsigned      fill;
    int unsigned      cap_limit;
    int unsigned      errors;
    int unsigned      checked;
    list_rsp_t        awaited_rsp [$];

    function new();
      foreach (slots[i]) slots[i] = '0;
      fill      = 0;
      cap_limit = CAP_RESET;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_capacity(input logic [CAP_W-1:0] limit);
      cap_limit = limit;
    endfunction

    function int unsigned pending();
      return awaited_rsp.size();
    endfunction

    function void apply_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val, input logic [POS_W-1:0] cnt);
      list_rsp_t   rsp;
      int unsigned room;
      int unsigned at;
      rsp.status     = STAT_OK;
      rsp.read_value = '0;
      // The limit never allows more entries than there are slots.
      room = (cap_limit > LIST_DEPTH) ? LIST_DEPTH : cap_limit;
      case (kind)
        REQ_INSERT: begin
          if (fill >= room) begin
            rsp.status = STAT_FULL;
          end else if (pos > fill) begin
            rsp.status = STAT_BAD_INDEX;
          end else begin
            at = (pos == 0) ? fill : pos - 1;
            for (int unsigned j = fill; j > at; j--) slots[j] = slots[j-1];
            slots[at] = val;
            fill++;
          end
        end
        REQ_DELETE: begin
          if (pos >= fill) begin
            rsp.status = STAT_BAD_INDEX;
          end else begin
            for (int unsigned j = pos; j + 1 < fill; j++) slots[j] = slots[j+1];
            slots[fill-1] = '0;
            fill--;
          end
        end
        REQ_REMOVE: begin
          if (cnt >= fill) begin
            rsp.status = STAT_BAD_COUNT;
          end else begin
            repeat (cnt) begin
              slots[fill-1] = '0;
              fill--;
            end
          end
        end
        REQ_CLEAR: begin
          foreach (slots[i]) slots[i] = '0;
          fill = 0;
        end
        REQ_READ: begin
          if (pos >= fill) rsp.status = STAT_BAD_INDEX;
          else rsp.read_value = slots[pos];
        end
        default: ;
      endcase
      rsp.length = LEN_W'(fill);
      awaited_rsp.push_back(rsp);
    endfunction

    task report(input string field, input logic [7:0] got, input logic [7:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("[%0t] response %0d: %s is %0h, expected %0h", $time, checked, field, got,
                 want);
    endtask

    task check_rsp(input logic [STAT_W-1:0] st, input logic [VAL_W-1:0] rd,
                   input logic [LEN_W-1:0] len);
      list_rsp_t want;
      checked++;
      if (awaited_rsp.size() == 0) begin
        report("length of a word nobody asked for", 8'(len), 8'h00);
        return;
      end
      want = awaited_rsp.pop_front();
      if (st !== want.status) report("status", 8'(st), 8'(want.status));
      if (rd !== want.read_value) report("read_value", rd, want.read_value);
      if (len !== want.length) report("length", 8'(len), 8'(want.length));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  pidl_req_if req_if ();
  pidl_rsp_if rsp_if ();

  list_tracker sb;

  // Chance in percent, per cycle, that the sender holds off or the receiver
  // stalls. Each phase of the run sets its own pair.
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;

  positional_insert_delete_list_top #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Response side. A word is taken at an edge where valid and ready were both
  // high just before it; ready for the next edge is then drawn at random.
  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready && sb != null)
      sb.check_rsp(rsp_if.status, rsp_if.read_value, rsp_if.length);
    rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // The watchdog counts edges on which neither channel moved a word. A hang
  // anywhere, in the block or in the stimulus, ends the run here.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("positional_insert_delete_list_top verification failed");
    $finish;
  end

  // Presents one request and holds it until the block takes it. The valid
  // stays high on return so that a request issued back to back follows with
  // no bubble; the next call either replaces the word or lowers valid.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val, input logic [POS_W-1:0] cnt);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.position <= pos;
    req_if.value    <= val;
    req_if.count    <= cnt;
    do @(posedge clk); while (!req_if.ready);
    sb.apply_request(kind, pos, val, cnt);
  endtask

  // Stops sending and waits for every awaited word. At least one edge passes,
  // so a following request never lowers and raises valid in one step.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // APB write of the capacity limit, setup phase then access phase. The upper data bits carry
  // noise, since only the low seven bits belong to the register.
  task automatic write_capacity(input logic [CAP_W-1:0] limit);
    repeat (3) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {(APB_DW - CAP_W)'($urandom), limit};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_capacity(limit);
  endtask

  // Walks the boundaries by hand: the empty list, append and insert before,
  // positions one past the end, reads out of range, remove counts of zero,
  // of the length and above, the unused codes, clear, and the capacity
  // limit at two, below the length, and at zero.
  task automatic directed_requests();
    send_request(REQ_READ,   7'd0, 8'h00, 7'd0);
    send_request(REQ_DELETE, 7'd0, 8'h00, 7'd0);
    send_request(REQ_REMOVE, 7'd0, 8'h00, 7'd0);
    send_request(REQ_INSERT, 7'd1, 8'h11, 7'd0);
    send_request(REQ_INSERT, 7'd0, 8'hFF, 7'd0);
    send_request(REQ_INSERT, 7'd1, 8'h00, 7'd0);
    send_request(REQ_INSERT, 7'd3, 8'hA5, 7'd0);
    send_request(REQ_INSERT, 7'd2, 8'h5A, 7'd0);
    for (int i = 0; i < 3; i++) send_request(REQ_READ, 7'(i), 8'h00, 7'd0);
    send_request(REQ_READ,   7'h7F, 8'hFF, 7'h7F);
    send_request(REQ_REMOVE, 7'd0,  8'h00, 7'd0);
    send_request(REQ_REMOVE, 7'd0,  8'h00, 7'h7F);
    send_request(REQ_REMOVE, 7'd0,  8'h00, 7'd3);
    send_request(REQ_REMOVE, 7'd0,  8'h00, 7'd1);
    send_request(REQ_DELETE, 7'h7F, 8'h00, 7'd0);
    send_request(REQ_DELETE, 7'd0,  8'h00, 7'd0);
    for (int k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++)
      send_request(3'(k), 7'h7F, 8'hFF, 7'h7F);
    send_request(REQ_CLEAR, 7'd0, 8'h00, 7'd0);

    // A limit of two: the third insert must report a full list.
    drain();
    write_capacity(7'd2);
    for (int i = 0; i < 3; i++) send_request(REQ_INSERT, 7'd0, 8'(8'h30 + i), 7'd0);
    // A limit under the current length keeps the entries but refuses inserts.
    drain();
    write_capacity(7'd1);
    send_request(REQ_INSERT, 7'd1, 8'h77, 7'd0);
    send_request(REQ_DELETE, 7'd0, 8'h00, 7'd0);
    // A limit of zero refuses every insert.
    drain();
    write_capacity(7'd0);
    send_request(REQ_INSERT, 7'd0, 8'h01, 7'd0);
    send_request(REQ_CLEAR,  7'd0, 8'h00, 7'd0);
  endtask

  // One random request. Most positions and counts are drawn inside the legal
  // range of the current length so that the list grows and shifts deeply; a
  // tenth or so, and a fifth of remove counts, are raw seven-bit values that mostly fail.
  task automatic random_request(input int unsigned ins_pct);
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] cnt;
    logic [VAL_W-1:0] val;
    int unsigned      roll;
    int unsigned      len;
    len  = sb.fill;
    val  = VAL_W'($urandom);
    pos  = POS_W'($urandom);
    cnt  = POS_W'($urandom);
    roll = $urandom_range(99);
    if (roll < ins_pct) begin
      kind = REQ_INSERT;
      if ($urandom_range(9) != 0) pos = POS_W'($urandom_range(len));
    end else begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        kind = REQ_DELETE;
        if ($urandom_range(9) != 0 && len > 0) pos = POS_W'($urandom_range(len - 1));
      end else if (roll < 82) begin
        kind = REQ_READ;
        if ($urandom_range(9) != 0 && len > 0) pos = POS_W'($urandom_range(len - 1));
      end else if (roll < 94) begin
        kind = REQ_REMOVE;
        if ($urandom_range(4) != 0 && len > 0)
          cnt = POS_W'($urandom_range((len > 4) ? 4 : len - 1));
      end else if (roll < 97) begin
        kind = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
      end else begin
        kind = REQ_CLEAR;
      end
    end
    send_request(kind, pos, val, cnt);
  endtask

  // One phase: a new capacity limit written while idle, new idle and stall
  // rates, then random requests. Now and then, and always halfway through,
  // the sender waits until every awaited word has come back.
  task automatic run_phase(input logic [CAP_W-1:0] limit, input int unsigned send_pct,
                           input int unsigned sink_pct, input int unsigned ins_pct,
                           input int unsigned n_items);
    drain();
    write_capacity(limit);
    send_idle_pct  = send_pct;
    sink_stall_pct = sink_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == n_items / 2 || $urandom_range(99) == 0) drain();
      random_request(ins_pct);
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= '0;
    req_if.position <= '0;
    req_if.value    <= '0;
    req_if.count    <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_capacity(CAP_RESET);
    directed_requests();

    // The limit of 127 exceeds the slot count, and the insert-heavy mix
    // fills the list to its physical depth. The small limits that follow
    // usually start below the length left behind.
    run_phase(7'd64,  0,  0,  60, 300);
    run_phase(7'd127, 61, 0,  75, 400);
    run_phase(7'd5,   0,  61, 50, 250);
    run_phase(7'd1,   34, 34, 45, 150);
    run_phase(7'd40,  34, 34, 60, 350);

    drain();
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("positional_insert_delete_list_top verification clean");
    end else begin
      $display("positional_insert_delete_list_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pidl_pkg.sv
sv/pidl_if.sv
sv/pidl_store.sv
sv/positional_insert_delete_list_top.sv
tb/positional_insert_delete_list_top_tb.sv
